[rtl/rtti_pkg.sv]
// Shared types and constants for the radix text to integer unit.
`timescale 1ns / 1ps

package rtti_pkg;

  localparam int unsigned BaseWidth  = 7;
  localparam int unsigned DigitWidth = 6;
  localparam int unsigned AccWidth   = 128;
  localparam int unsigned HalfWidth  = 64;

  localparam logic [BaseWidth-1:0] BASE_RESET   = 7'd10;
  localparam logic [BaseWidth-1:0] BASE_B32     = 7'd32;
  localparam logic [BaseWidth-1:0] BASE_B64_LO  = 7'd37;
  localparam logic [BaseWidth-1:0] BASE_B64_HI  = 7'd64;
  localparam logic [BaseWidth-1:0] BASE_ALNUM_HI = 7'd36;

  // Digit offsets of the alphabets.
  localparam logic [DigitWidth-1:0] OFS_B32_NUM   = 6'd26;
  localparam logic [DigitWidth-1:0] OFS_B64_LOWER = 6'd26;
  localparam logic [DigitWidth-1:0] OFS_B64_NUM   = 6'd52;
  localparam logic [DigitWidth-1:0] DIG_B64_PLUS  = 6'd62;
  localparam logic [DigitWidth-1:0] DIG_B64_SLASH = 6'd63;
  localparam logic [DigitWidth-1:0] OFS_ALNUM_LET = 6'd10;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [HalfWidth-1:0] value_high;
    logic [HalfWidth-1:0] value_low;
    logic                 value_wide;
    logic                 overflow_seen;
  } out_item_t;

  typedef struct packed {
    logic                  ok;
    logic [DigitWidth-1:0] value;
  } digit_t;

endpackage

[rtl/radix_text_to_integer_unit.sv]
// Top level of the radix text to integer unit.
`timescale 1ns / 1ps

// Usage:
// The input channel carries one character per transfer (in_valid_i, in_stall_o,
// in_item_i). Characters of the configured base are folded into a 128-bit
// accumulator as acc * base + digit; other characters are skipped. The
// character flagged last_char ends the literal: its transfer yields one result
// on the output channel (out_valid_o, out_stall_i, out_item_o) holding the value
// halves, a wide flag and the sticky overflow flag, and the accumulator clears.
// Throughput is one character per cycle unless a last character waits on a
// stalled receiver; the multiply-add on the accumulator loop is combinational.
// The base register is written through cfg_we_i and cfg_data_i; the user must
// write it only while idle, which the block does not enforce. Reset clears the
// accumulator, the overflow flag and both valid bits and sets the base to ten.
// While the receiver stalls, a pending result holds; ordinary characters keep
// flowing, and a last character waits in the input register, which then stalls
// the sender.
module radix_text_to_integer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rtti_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rtti_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [rtti_pkg::BaseWidth-1:0]    cfg_data_i
);
  import rtti_pkg::*;

  logic [BaseWidth-1:0] base_q;
  logic                 in_valid_q, in_valid_d;
  in_item_t             in_item_q;
  logic [AccWidth-1:0]  acc_q, acc_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q;

  digit_t               digit;
  logic [AccWidth-1:0]  acc_next;
  logic                 mac_ovf;
  logic                 in_take;
  logic                 consume;
  logic                 out_free;
  logic                 out_load;
  logic [AccWidth-1:0]  acc_upd;
  logic                 ovf_upd;

  rtti_digit u_digit (
    .char_code_i   (in_item_q.char_code),
    .number_base_i (base_q),
    .digit_o       (digit)
  );

  rtti_mac u_mac (
    .acc_i         (acc_q),
    .number_base_i (base_q),
    .digit_i       (digit.value),
    .acc_o         (acc_next),
    .overflow_o    (mac_ovf)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign consume    = in_valid_q && (!in_item_q.last_char || out_free);
  assign out_load   = consume && in_item_q.last_char;
  assign in_stall_o = in_valid_q && !consume;
  assign in_take    = in_valid_i && !in_stall_o;

  assign acc_upd = digit.ok ? acc_next : acc_q;
  assign ovf_upd = ovf_q || (digit.ok && mac_ovf);

  always_comb begin
    in_valid_d  = in_take ? 1'b1 : (consume ? 1'b0 : in_valid_q);
    out_valid_d = out_load ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    if (consume) begin
      acc_d = in_item_q.last_char ? '0 : acc_upd;
      ovf_d = in_item_q.last_char ? 1'b0 : ovf_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BASE_RESET;
      in_valid_q  <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      in_valid_q  <= in_valid_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (out_load) begin
      out_q.value_high    <= acc_upd[AccWidth-1:HalfWidth];
      out_q.value_low     <= acc_upd[HalfWidth-1:0];
      out_q.value_wide    <= |acc_upd[AccWidth-1:HalfWidth];
      out_q.overflow_seen <= ovf_upd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (acc_q == '0) && !ovf_q)
    else $error("accumulator not cleared after last character");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && in_item_q.last_char && out_valid_q)
    else $error("input stalled without a blocked last character");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten while held");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q && !out_load |=> ovf_q)
    else $error("overflow flag dropped inside a literal");

  a_acc_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !consume |=> $stable(acc_q))
    else $error("accumulator changed without a consumed character");
`endif

endmodule

[rtl/rtti_digit.sv]
// Character to digit decoder for the three alphabets.
`timescale 1ns / 1ps

module rtti_digit (
  input  logic [7:0]                   char_code_i,
  input  logic [rtti_pkg::BaseWidth-1:0] number_base_i,
  output rtti_pkg::digit_t             digit_o
);
  import rtti_pkg::*;

  logic                  is_upper;
  logic                  is_lower;
  logic                  is_num;
  logic                  in_alpha;
  logic [DigitWidth-1:0] val;
  logic [7:0]            ofs_upper;
  logic [7:0]            ofs_lower;
  logic [7:0]            ofs_num;

  assign is_upper  = (char_code_i >= CH_UA) && (char_code_i <= CH_UZ);
  assign is_lower  = (char_code_i >= CH_LA) && (char_code_i <= CH_LZ);
  assign is_num    = (char_code_i >= CH_0) && (char_code_i <= CH_9);
  assign ofs_upper = char_code_i - CH_UA;
  assign ofs_lower = char_code_i - CH_LA;
  assign ofs_num   = char_code_i - CH_0;

  always_comb begin
    in_alpha = 1'b0;
    val      = '0;
    if (number_base_i == BASE_B32) begin
      if (is_lower) begin
        in_alpha = 1'b1;
        val      = ofs_lower[DigitWidth-1:0];
      end else if (is_upper) begin
        in_alpha = 1'b1;
        val      = ofs_upper[DigitWidth-1:0];
      end else if ((char_code_i >= CH_2) && (char_code_i <= CH_7)) begin
        in_alpha = 1'b1;
        val      = 6'(char_code_i - CH_2) + OFS_B32_NUM;
      end
    end else if ((number_base_i >= BASE_B64_LO) && (number_base_i <= BASE_B64_HI)) begin
      if (is_upper) begin
        in_alpha = 1'b1;
        val      = ofs_upper[DigitWidth-1:0];
      end else if (is_lower) begin
        in_alpha = 1'b1;
        val      = ofs_lower[DigitWidth-1:0] + OFS_B64_LOWER;
      end else if (is_num) begin
        in_alpha = 1'b1;
        val      = ofs_num[DigitWidth-1:0] + OFS_B64_NUM;
      end else if (char_code_i == CH_PLUS) begin
        in_alpha = 1'b1;
        val      = DIG_B64_PLUS;
      end else if (char_code_i == CH_SLASH) begin
        in_alpha = 1'b1;
        val      = DIG_B64_SLASH;
      end
    end else if (number_base_i <= BASE_ALNUM_HI) begin
      if (is_num) begin
        in_alpha = 1'b1;
        val      = ofs_num[DigitWidth-1:0];
      end else if (is_upper) begin
        in_alpha = 1'b1;
        val      = ofs_upper[DigitWidth-1:0] + OFS_ALNUM_LET;
      end else if (is_lower) begin
        in_alpha = 1'b1;
        val      = ofs_lower[DigitWidth-1:0] + OFS_ALNUM_LET;
      end
    end
  end

  // A digit that is not below the base is dropped like a foreign character.
  assign digit_o.ok    = in_alpha && ({1'b0, val} < number_base_i);
  assign digit_o.value = val;

endmodule

[rtl/rtti_mac.sv]
// Multiply-accumulate step: acc * base + digit modulo 2^128 with overflow detect.
`timescale 1ns / 1ps

module rtti_mac (
  input  logic [rtti_pkg::AccWidth-1:0]   acc_i,
  input  logic [rtti_pkg::BaseWidth-1:0]  number_base_i,
  input  logic [rtti_pkg::DigitWidth-1:0] digit_i,
  output logic [rtti_pkg::AccWidth-1:0]   acc_o,
  output logic                            overflow_o
);
  import rtti_pkg::*;

  localparam int unsigned SumWidth = AccWidth + BaseWidth;

  logic [SumWidth-1:0] sum;

  // The base is at most 127 and the digit at most 63, so the sum never carries past SumWidth bits.
  assign sum        = SumWidth'(acc_i) * SumWidth'(number_base_i) + SumWidth'(digit_i);
  assign acc_o      = sum[AccWidth-1:0];
  assign overflow_o = |sum[SumWidth-1:AccWidth];

endmodule

[sim/radix_text_to_integer_unit_tb.sv]
// Self-checking testbench for the radix text to integer unit.
`timescale 1ns / 1ps

module radix_text_to_integer_unit_tb;
  import rtti_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned ITEM_TARGET  = 600;
  localparam int unsigned HOLD_CYCLES  = 80;

  // Predicts the value of each literal and checks the unit's results against it.
  class literal_scoreboard;
    logic [BaseWidth-1:0] base;
    logic [AccWidth-1:0]  acc;
    logic                 ovf;
    out_item_t            expected_values[$];
    int unsigned          mismatches;
    int unsigned          checked;
    int unsigned          wide_count;
    int unsigned          ovf_count;

    function new();
      base = BASE_RESET;
      acc = '0;
      ovf = 1'b0;
      mismatches = 0;
      checked = 0;
      wide_count = 0;
      ovf_count = 0;
    endfunction

    // Digit of a character in the given base, or -1 if the unit skips it.
    function int digit_value(logic [BaseWidth-1:0] b, logic [7:0] c);
      int d;
      int bi;
      d = -1;
      bi = b;
      if (b == BASE_B32) begin
        if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA;
        else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA;
        else if (c >= CH_2 && c <= CH_7) d = c - CH_2 + OFS_B32_NUM;
      end else if (b >= BASE_B64_LO && b <= BASE_B64_HI) begin
        if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA;
        else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA + OFS_B64_LOWER;
        else if (c >= CH_0 && c <= CH_9) d = c - CH_0 + OFS_B64_NUM;
        else if (c == CH_PLUS) d = DIG_B64_PLUS;
        else if (c == CH_SLASH) d = DIG_B64_SLASH;
      end else if (b <= BASE_ALNUM_HI) begin
        if (c >= CH_0 && c <= CH_9) d = c - CH_0;
        else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA + OFS_ALNUM_LET;
        else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA + OFS_ALNUM_LET;
      end
      if (d >= bi) d = -1;
      return d;
    endfunction

    function void note_char(in_item_t it);
      int                 d;
      logic [AccWidth+7:0] prod;
      logic [AccWidth+7:0] acc_ext;
      out_item_t          r;
      d = digit_value(base, it.char_code);
      if (d >= 0) begin
        acc_ext = {8'b0, acc};
        prod = acc_ext * base + d;
        if (|prod[AccWidth+7:AccWidth]) ovf = 1'b1;
        acc = prod[AccWidth-1:0];
      end
      if (it.last_char) begin
        r.value_high    = acc[AccWidth-1:HalfWidth];
        r.value_low     = acc[HalfWidth-1:0];
        r.value_wide    = |acc[AccWidth-1:HalfWidth];
        r.overflow_seen = ovf;
        expected_values.push_back(r);
        acc = '0;
        ovf = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [HalfWidth-1:0] exp_v,
                                logic [HalfWidth-1:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_value(out_item_t got);
      out_item_t e;
      if (expected_values.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %0h_%0h", $time,
                 got.value_high, got.value_low);
        return;
      end
      e = expected_values.pop_front();
      checked++;
      if (e.value_wide) wide_count++;
      if (e.overflow_seen) ovf_count++;
      compare_field("value_high", e.value_high, got.value_high);
      compare_field("value_low", e.value_low, got.value_low);
      compare_field("value_wide", e.value_wide, got.value_wide);
      compare_field("overflow_seen", e.overflow_seen, got.overflow_seen);
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_item_o;
  logic                 cfg_we_i;
  logic [BaseWidth-1:0] cfg_data_i;

  literal_scoreboard sb;
  int unsigned       cycles;
  int unsigned       sent_count;
  int unsigned       base_writes;
  bit                hold_req;
  bit                sender_calm;
  logic [BaseWidth-1:0] base_menu [16] = '{7'd0, 7'd1, 7'd2, 7'd7, 7'd8, 7'd10, 7'd16,
                                            7'd31, 7'd32, 7'd33, 7'd36, 7'd37, 7'd50,
                                            7'd63, 7'd64, 7'd127};

  radix_text_to_integer_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL radix_text_to_integer_unit");
      $finish;
    end
  end

  // Both channels are observed at the rising edge where a transfer happens.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_char(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_value(out_item_o);
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    int stall_left;
    int calm_left;
    int r;
    stall_left = 0;
    calm_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) calm_left = $urandom_range(20, 60);
        else if (r < 6) stall_left = $urandom_range(5, 25);
        out_stall_i <= (r >= 3 && r < 30);
      end
    end
  end

  function int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one character and returns at the edge where its transfer happens.
  task automatic send_char(logic [7:0] c, logic last);
    int n;
    n = sender_gap();
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i.char_code <= c;
    in_item_i.last_char <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_base(logic [BaseWidth-1:0] b);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= b;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.base = b;
    base_writes++;
  endtask

  function logic [7:0] char_for_digit(logic [BaseWidth-1:0] b, int d);
    logic [7:0] letter_base;
    letter_base = $urandom_range(0, 1) ? CH_UA : CH_LA;
    if (b == BASE_B32) begin
      if (d < OFS_B32_NUM) return 8'(letter_base + d);
      return 8'(CH_2 + d - OFS_B32_NUM);
    end
    if (b >= BASE_B64_LO) begin
      if (d < OFS_B64_LOWER) return 8'(CH_UA + d);
      if (d < OFS_B64_NUM) return 8'(CH_LA + d - OFS_B64_LOWER);
      if (d < DIG_B64_PLUS) return 8'(CH_0 + d - OFS_B64_NUM);
      if (d == DIG_B64_PLUS) return CH_PLUS;
      return CH_SLASH;
    end
    if (d < OFS_ALNUM_LET) return 8'(CH_0 + d);
    return 8'(letter_base + d - OFS_ALNUM_LET);
  endfunction

  // One literal: for bases 1 to 64 mostly valid digits; other bytes arbitrary.
  task automatic send_literal(logic [BaseWidth-1:0] b);
    int         len;
    int         r;
    bit         has_digits;
    logic [7:0] c;
    logic       last;
    has_digits = (b >= 1 && b <= BASE_B64_HI);
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(1, 12);
    else if (r < 95) len = $urandom_range(13, 30);
    else len = $urandom_range(31, 48);
    for (int i = 0; i < len; i++) begin
      if (has_digits && $urandom_range(0, 99) < 85)
        c = char_for_digit(b, $urandom_range(0, int'(b) - 1));
      else
        c = 8'($urandom_range(0, 255));
      last = (i == len - 1);
      send_char(c, last);
      sent_count++;
    end
  endtask

  initial begin
    logic [BaseWidth-1:0] b;
    int unsigned          sent0;
    sb = new();
    cycles = 0;
    sent_count = 0;
    base_writes = 0;
    hold_req = 1'b0;
    sender_calm = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting from the reset base of ten.
    send_char(8'h00, 1'b0);
    send_char(CH_9, 1'b0);
    send_char(8'hff, 1'b1);
    send_char(8'h20, 1'b1);
    write_base(BASE_ALNUM_HI);
    send_char(CH_LZ, 1'b0);
    send_char(CH_UZ, 1'b1);
    write_base(BASE_B32);
    send_char(CH_LA, 1'b0);
    send_char(CH_7, 1'b0);
    send_char(CH_2, 1'b1);
    write_base(BASE_B64_HI);
    send_char(CH_UA, 1'b0);
    send_char(CH_SLASH, 1'b0);
    send_char(CH_PLUS, 1'b0);
    send_char(CH_9, 1'b0);
    send_char(CH_LZ, 1'b1);
    // The base changes in the middle of a literal.
    send_char(CH_UA + 8'd1, 1'b0);
    write_base(7'd16);
    send_char(CH_LA + 8'd5, 1'b1);
    write_base(7'd0);
    send_char(CH_0, 1'b1);
    write_base(7'd1);
    send_char(CH_0, 1'b0);
    send_char(CH_0 + 8'd1, 1'b1);
    write_base(7'd127);
    send_char(CH_UA, 1'b1);

    // Long receiver hold-off while the sender keeps offering short literals.
    write_base(7'd16);
    sender_calm = 1'b1;
    hold_req = 1'b1;
    repeat (8) send_literal(7'd16);
    sender_calm = 1'b0;

    while (sent_count < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 70) b = base_menu[4'($urandom_range(0, 15))];
      else b = BaseWidth'($urandom_range(0, 127));
      write_base(b);
      sent0 = sent_count;
      while (sent_count - sent0 < 50) send_literal(b);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d literals over %0d base writes (%0d characters sent).",
             sb.checked, base_writes, sent_count);
    $display("Results above 64 bits: %0d, with overflow: %0d.", sb.wide_count,
             sb.ovf_count);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS radix_text_to_integer_unit");
    end else begin
      $display("FAIL radix_text_to_integer_unit");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rtti_pkg.sv
rtl/rtti_digit.sv
rtl/rtti_mac.sv
rtl/radix_text_to_integer_unit.sv
sim/radix_text_to_integer_unit_tb.sv
